// ===== sv/itp_pkg.sv =====
package itp_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int NORM_W    = 16;
  localparam int ERR_W     = 16;
  localparam int GAIN_W    = 12;
  localparam int DUTY_W    = 14;
  localparam int FRAC_BITS = 15;
  localparam int NUMER_W   = 31;
  localparam int DENOM_W   = 17;
  localparam int QUOT_W    = 16;
  localparam int ACC_W     = 32;
  localparam int PROD_W    = 30;
  localparam int STEP_W    = 4;
  localparam int DIV_CNT_W = 5;
  localparam int ADDR_W    = 5;
  localparam int DATA_W    = 32;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST      = 12'd1200;
  localparam logic [GAIN_W-1:0]   GAIN_D_RST      = 12'd200;
  localparam logic [DUTY_W-1:0]   CENTER_DUTY_RST = 14'd838;
  localparam logic [DUTY_W-1:0]   STEER_MIN_RST   = 14'd630;
  localparam logic [DUTY_W-1:0]   STEER_MAX_RST   = 14'd1040;
  localparam logic [SAMPLE_W-1:0] PEAK_RST        = 8'd255;
  localparam logic [SAMPLE_W-1:0] FLOOR_RST       = 8'd5;

  typedef enum logic [2:0] {
    REG_GAIN_P,
    REG_GAIN_D,
    REG_CENTER_DUTY,
    REG_STEER_MIN,
    REG_STEER_MAX
  } reg_idx_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_DIV_L,
    OP_SAVE_L,
    OP_DIV_R,
    OP_SAVE_R,
    OP_DIV_E,
    OP_SAVE_E,
    OP_MUL_P,
    OP_MUL_D,
    OP_OUT
  } dp_op_t;

  typedef enum logic [1:0] {
    COND_NEVER,
    COND_NO_IN,
    COND_DIV_BUSY,
    COND_OUT_FULL
  } cond_t;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_IDLE   = 4'd0;
  localparam step_t STEP_DIV_L  = 4'd1;
  localparam step_t STEP_WAIT_L = 4'd2;
  localparam step_t STEP_SAVE_L = 4'd3;
  localparam step_t STEP_DIV_R  = 4'd4;
  localparam step_t STEP_WAIT_R = 4'd5;
  localparam step_t STEP_SAVE_R = 4'd6;
  localparam step_t STEP_DIV_E  = 4'd7;
  localparam step_t STEP_WAIT_E = 4'd8;
  localparam step_t STEP_SAVE_E = 4'd9;
  localparam step_t STEP_MUL_P  = 4'd10;
  localparam step_t STEP_MUL_D  = 4'd11;
  localparam step_t STEP_OUT    = 4'd12;

  typedef struct packed {
    dp_op_t op;
    cond_t  cond;
    step_t  target;
    logic   last;
  } uword_t;

  typedef struct packed {
    logic [GAIN_W-1:0] gain_p;
    logic [GAIN_W-1:0] gain_d;
    logic [DUTY_W-1:0] center_duty;
    logic [DUTY_W-1:0] steer_min;
    logic [DUTY_W-1:0] steer_max;
  } cfg_t;

  typedef struct packed {
    logic div_busy;
    logic out_full;
  } dp_status_t;

  function automatic uword_t microcode(step_t s);
    uword_t w;
    w = '{op: OP_NONE, cond: COND_NEVER, target: STEP_IDLE, last: 1'b1};
    case (s)
      STEP_IDLE:   w = '{op: OP_LOAD,   cond: COND_NO_IN,    target: STEP_IDLE,   last: 1'b0};
      STEP_DIV_L:  w = '{op: OP_DIV_L,  cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_WAIT_L: w = '{op: OP_NONE,   cond: COND_DIV_BUSY, target: STEP_WAIT_L, last: 1'b0};
      STEP_SAVE_L: w = '{op: OP_SAVE_L, cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_DIV_R:  w = '{op: OP_DIV_R,  cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_WAIT_R: w = '{op: OP_NONE,   cond: COND_DIV_BUSY, target: STEP_WAIT_R, last: 1'b0};
      STEP_SAVE_R: w = '{op: OP_SAVE_R, cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_DIV_E:  w = '{op: OP_DIV_E,  cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_WAIT_E: w = '{op: OP_NONE,   cond: COND_DIV_BUSY, target: STEP_WAIT_E, last: 1'b0};
      STEP_SAVE_E: w = '{op: OP_SAVE_E, cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_MUL_P:  w = '{op: OP_MUL_P,  cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_MUL_D:  w = '{op: OP_MUL_D,  cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b0};
      STEP_OUT:    w = '{op: OP_OUT,    cond: COND_OUT_FULL, target: STEP_OUT,    last: 1'b1};
      default:     w = '{op: OP_NONE,   cond: COND_NEVER,    target: STEP_IDLE,   last: 1'b1};
    endcase
    return w;
  endfunction

endpackage

// ===== sv/inductor_track_pd_steering_core.sv =====
// Difference-over-sum PD steering controller. Each input word carries a left and a
// right 8-bit inductor sample; each channel's running min/max is widened, both samples
// are scaled to Q1.15, the error (l-r)/(l+r) is formed, and one output word gives the
// clamped servo duty and the signed Q1.15 error. The microcode program runs three
// 16-bit restoring divisions back to back on one shared divider (each with a load
// and a save step), then two multiply-accumulate steps and the clamp. A new word is
// taken only while the program sits in its idle step; a finished output word may wait
// in the output register while the next item is already being worked on. Gains and
// clamps are set through the APB port: gain_p 0x00, gain_d 0x04, center_duty 0x08,
// steer_min 0x0c, steer_max 0x10.
module inductor_track_pd_steering_core
  import itp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [15:0]       s_tdata,   // left_sample[7:0], right_sample[15:8]
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // steer_duty[13:0], track_error[29:14], zero[31:30]
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t       cfg;
  dp_status_t status;
  dp_op_t     op;
  reg_idx_t   reg_idx;
  logic       cfg_wr;
  logic [DUTY_W-1:0] steer_duty;
  logic [ERR_W-1:0]  track_error;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gain_p      <= GAIN_P_RST;
      cfg.gain_d      <= GAIN_D_RST;
      cfg.center_duty <= CENTER_DUTY_RST;
      cfg.steer_min   <= STEER_MIN_RST;
      cfg.steer_max   <= STEER_MAX_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_GAIN_P:      cfg.gain_p      <= pwdata[GAIN_W-1:0];
        REG_GAIN_D:      cfg.gain_d      <= pwdata[GAIN_W-1:0];
        REG_CENTER_DUTY: cfg.center_duty <= pwdata[DUTY_W-1:0];
        REG_STEER_MIN:   cfg.steer_min   <= pwdata[DUTY_W-1:0];
        REG_STEER_MAX:   cfg.steer_max   <= pwdata[DUTY_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_GAIN_P:      prdata = DATA_W'(cfg.gain_p);
      REG_GAIN_D:      prdata = DATA_W'(cfg.gain_d);
      REG_CENTER_DUTY: prdata = DATA_W'(cfg.center_duty);
      REG_STEER_MIN:   prdata = DATA_W'(cfg.steer_min);
      REG_STEER_MAX:   prdata = DATA_W'(cfg.steer_max);
      default:         prdata = '0;
    endcase
  end

  itp_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .in_ready (s_tready),
    .op       (op)
  );

  itp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .op           (op),
    .cfg          (cfg),
    .left_sample  (s_tdata[7:0]),
    .right_sample (s_tdata[15:8]),
    .out_ready    (m_tready),
    .status       (status),
    .out_valid    (m_tvalid),
    .steer_duty   (steer_duty),
    .track_error  (track_error)
  );

  assign m_tdata = {2'b00, track_error, steer_duty};

  a_load_only_on_accept: assert property (@(posedge clk) disable iff (rst)
    (op == OP_LOAD) |-> (s_tvalid && s_tready))
    else $error("sample load without an accepted word");

  a_no_ready_after_accept: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input ready right after an accepted word");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    (op == OP_DIV_L || op == OP_DIV_R || op == OP_DIV_E) |-> !status.div_busy)
    else $error("divider restarted while busy");

  a_no_out_overwrite: assert property (@(posedge clk) disable iff (rst)
    (op == OP_OUT) |-> !(m_tvalid && !m_tready))
    else $error("output word overwritten before it was taken");

endmodule

// ===== sv/itp_div.sv =====
module itp_div
  import itp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [NUMER_W-1:0] numer,
  input  logic [DENOM_W-1:0] denom,
  output logic [QUOT_W-1:0]  quot,
  output logic               busy
);

  logic [DIV_CNT_W-1:0] cnt;
  logic [DENOM_W-1:0]   rem;
  logic [DENOM_W-1:0]   den;
  logic [QUOT_W-1:0]    nlo;
  logic [DENOM_W:0]     trial;
  logic                 fits;

  assign busy  = (cnt != '0);
  assign trial = {rem, nlo[QUOT_W-1]};
  assign fits  = (trial >= {1'b0, den});

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(QUOT_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= {{(DENOM_W-(NUMER_W-QUOT_W)){1'b0}}, numer[NUMER_W-1:QUOT_W]};
      nlo  <= numer[QUOT_W-1:0];
      den  <= denom;
      quot <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DENOM_W'(trial - {1'b0, den});
      end else begin
        rem <= trial[DENOM_W-1:0];
      end
      quot <= {quot[QUOT_W-2:0], fits};
      nlo  <= {nlo[QUOT_W-2:0], 1'b0};
    end
  end

endmodule

// ===== sv/itp_dp.sv =====
module itp_dp
  import itp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  dp_op_t              op,
  input  cfg_t                cfg,
  input  logic [SAMPLE_W-1:0] left_sample,
  input  logic [SAMPLE_W-1:0] right_sample,
  input  logic                out_ready,
  output dp_status_t          status,
  output logic                out_valid,
  output logic [DUTY_W-1:0]   steer_duty,
  output logic [ERR_W-1:0]    track_error
);

  logic [SAMPLE_W-1:0] left_peak, left_floor, right_peak, right_floor;
  logic [SAMPLE_W-1:0] left_s, right_s;
  logic [NORM_W-1:0]   norm_l, norm_r;
  logic signed [ERR_W-1:0] err, prev_err;
  logic signed [ACC_W-1:0] acc;

  logic               div_start;
  logic [NUMER_W-1:0] div_numer;
  logic [DENOM_W-1:0] div_denom;
  logic [QUOT_W-1:0]  quot;
  logic               div_busy;

  logic [SAMPLE_W-1:0] left_range, right_range;
  logic                neg;
  logic [NORM_W-1:0]   mag_diff;
  logic [NORM_W:0]     norm_sum;
  logic signed [ERR_W-1:0] err_next;

  logic [GAIN_W-1:0]         mul_a;
  logic signed [ERR_W:0]     mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   addend;
  logic signed [ACC_W-1:0]   acc_next;

  logic signed [ACC_W-FRAC_BITS-1:0] duty_raw, duty_hi, duty_lo, smax_s, smin_s;

  itp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (div_numer),
    .denom (div_denom),
    .quot  (quot),
    .busy  (div_busy)
  );

  assign left_range  = left_peak - left_floor;
  assign right_range = right_peak - right_floor;
  assign neg         = (norm_l < norm_r);
  assign mag_diff    = neg ? (norm_r - norm_l) : (norm_l - norm_r);
  assign norm_sum    = {1'b0, norm_l} + {1'b0, norm_r};

  always_comb begin
    div_start = 1'b0;
    div_numer = '0;
    div_denom = '0;
    unique case (op)
      OP_DIV_L: begin
        div_start = 1'b1;
        div_numer = NUMER_W'({left_s - left_floor, {FRAC_BITS{1'b0}}});
        div_denom = DENOM_W'(left_range);
      end
      OP_DIV_R: begin
        div_start = 1'b1;
        div_numer = NUMER_W'({right_s - right_floor, {FRAC_BITS{1'b0}}});
        div_denom = DENOM_W'(right_range);
      end
      OP_DIV_E: begin
        div_start = 1'b1;
        div_numer = NUMER_W'({mag_diff, {FRAC_BITS{1'b0}}});
        div_denom = norm_sum;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // full-scale positive error saturates
  always_comb begin
    if (norm_sum == '0) begin
      err_next = '0;
    end else if (neg) begin
      err_next = ~quot + 1'b1;
    end else if (quot[QUOT_W-1]) begin
      err_next = {1'b0, {(ERR_W-1){1'b1}}};
    end else begin
      err_next = quot;
    end
  end

  // one shared multiplier for both gain terms
  always_comb begin
    if (op == OP_MUL_P) begin
      mul_a  = cfg.gain_p;
      mul_b  = {err[ERR_W-1], err};
      addend = ACC_W'({cfg.center_duty, {FRAC_BITS{1'b0}}});
    end else begin
      mul_a  = cfg.gain_d;
      mul_b  = {err[ERR_W-1], err} - {prev_err[ERR_W-1], prev_err};
      addend = acc;
    end
    prod     = $signed({1'b0, mul_a}) * mul_b;
    acc_next = addend + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  end

  // upper clamp first, then lower
  always_comb begin
    duty_raw = acc[ACC_W-1:FRAC_BITS];
    smax_s   = $signed({{(ACC_W-FRAC_BITS-DUTY_W){1'b0}}, cfg.steer_max});
    smin_s   = $signed({{(ACC_W-FRAC_BITS-DUTY_W){1'b0}}, cfg.steer_min});
    duty_hi  = (duty_raw > smax_s) ? smax_s : duty_raw;
    duty_lo  = (duty_hi < smin_s) ? smin_s : duty_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_peak   <= PEAK_RST;
      left_floor  <= FLOOR_RST;
      right_peak  <= PEAK_RST;
      right_floor <= FLOOR_RST;
      prev_err    <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (op == OP_LOAD) begin
        if (left_sample >= left_peak) begin
          left_peak <= left_sample;
        end
        if (left_sample <= left_floor) begin
          left_floor <= left_sample;
        end
        if (right_sample >= right_peak) begin
          right_peak <= right_sample;
        end
        if (right_sample <= right_floor) begin
          right_floor <= right_sample;
        end
      end
      if (op == OP_OUT) begin
        prev_err  <= err;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        left_s  <= left_sample;
        right_s <= right_sample;
      end
      OP_SAVE_L: begin
        norm_l <= (left_range == '0) ? '0 : quot;
      end
      OP_SAVE_R: begin
        norm_r <= (right_range == '0) ? '0 : quot;
      end
      OP_SAVE_E: begin
        err <= err_next;
      end
      OP_MUL_P, OP_MUL_D: begin
        acc <= acc_next;
      end
      OP_OUT: begin
        steer_duty  <= duty_lo[DUTY_W-1:0];
        track_error <= err;
      end
      default: begin
      end
    endcase
  end

  assign status.div_busy = div_busy;
  assign status.out_full = out_valid && !out_ready;

endmodule

// ===== sv/itp_seq.sv =====
module itp_seq
  import itp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  dp_status_t status,
  output logic       in_ready,
  output dp_op_t     op
);

  step_t  step, step_next;
  uword_t uw;
  logic   jump;

  assign uw = microcode(step);

  always_comb begin
    unique case (uw.cond)
      COND_NEVER:    jump = 1'b0;
      COND_NO_IN:    jump = !in_valid;
      COND_DIV_BUSY: jump = status.div_busy;
      COND_OUT_FULL: jump = status.out_full;
      default:       jump = 1'b0;
    endcase
  end

  // a step whose jump is taken is held and does not execute
  always_comb begin
    if (jump) begin
      step_next = uw.target;
      op        = OP_NONE;
    end else begin
      step_next = uw.last ? STEP_IDLE : step + 1'b1;
      op        = uw.op;
    end
  end

  assign in_ready = (step == STEP_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== dv/tb_inductor_track_pd_steering_core.sv =====
`timescale 1ns / 1ps

module tb_inductor_track_pd_steering_core;
  import itp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int MAX_REPORTS    = 10;
  localparam int DUTY_TOP       = 10000;
  localparam int GAIN_TOP       = 4095;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_WORDS    = 60;
  localparam int BURST_WORDS    = 150;
  localparam logic [2:0] REG_UNMAPPED = 3'd6;
  localparam logic [2:0] REG_TOP_HOLE = 3'd7;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic [ERR_W-1:0]  err;
  } steer_word_t;

  logic              clk      = 1'b0;
  logic              rst      = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [15:0]       s_tdata  = '0;  // left_sample[7:0], right_sample[15:8]
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [31:0]       m_tdata;        // steer_duty[13:0], track_error[29:14], zero[31:30]
  logic              psel     = 1'b0;
  logic              penable  = 1'b0;
  logic              pwrite   = 1'b0;
  logic [ADDR_W-1:0] paddr    = '0;
  logic [DATA_W-1:0] pwdata   = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  inductor_track_pd_steering_core u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  cfg_t          cfg_now;
  logic [7:0]    l_hi, l_lo, r_hi, r_lo;
  longint        last_err;
  steer_word_t   pending_steer_q[$];
  steer_word_t   exp_word;
  bit            idle_on = 1'b1;
  int            fail_cnt = 0;
  int            idle_cycles = 0;

  always #6 clk = ~clk;

  always @(negedge clk) begin
    m_tready = !idle_on || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic note_fail(input string msg);
    fail_cnt++;
    if (fail_cnt <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_steer_q.size() == 0) begin
        note_fail($sformatf("unexpected word %h", m_tdata));
      end else begin
        exp_word = pending_steer_q.pop_front();
        if (m_tdata[13:0] !== exp_word.duty)
          note_fail($sformatf("steer_duty exp %0d got %0d", exp_word.duty, m_tdata[13:0]));
        if (m_tdata[29:14] !== exp_word.err)
          note_fail($sformatf("track_error exp %0d got %0d",
                              $signed(exp_word.err), $signed(m_tdata[29:14])));
      end
    end
  end

  function automatic longint scale_channel(input logic [7:0] s, inout logic [7:0] hi,
                                           inout logic [7:0] lo);
    if (s >= hi) hi = s;
    if (s <= lo) lo = s;
    if (hi == lo) return 0;
    return (longint'(s - lo) << FRAC_BITS) / longint'(hi - lo);
  endfunction

  function automatic steer_word_t predict_steer(input logic [7:0] ls, input logic [7:0] rs);
    longint      ln, rn, sum, e, drive, duty;
    steer_word_t w;
    ln  = scale_channel(ls, l_hi, l_lo);
    rn  = scale_channel(rs, r_hi, r_lo);
    sum = ln + rn;
    if (sum == 0) begin
      e = 0;
    end else begin
      e = ((ln - rn) * 32768) / sum;
      if (e > 32767) e = 32767;
      if (e < -32768) e = -32768;
    end
    drive = longint'(cfg_now.gain_p) * e + longint'(cfg_now.gain_d) * (e - last_err)
          + longint'(cfg_now.center_duty) * 32768;
    duty = drive >>> FRAC_BITS;
    if (duty > longint'(cfg_now.steer_max)) duty = longint'(cfg_now.steer_max);
    if (duty < longint'(cfg_now.steer_min)) duty = longint'(cfg_now.steer_min);
    last_err = e;
    w.duty = duty[DUTY_W-1:0];
    w.err  = e[ERR_W-1:0];
    return w;
  endfunction

  task automatic send_samples(input logic [7:0] ls, input logic [7:0] rs);
    if (idle_on && $urandom_range(99) < 30) begin
      s_tvalid = 1'b0;
      repeat ($urandom_range(1, 70)) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {rs, ls};
    do @(posedge clk); while (!s_tready);
    pending_steer_q.push_back(predict_steer(ls, rs));
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_steer_q.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_GAIN_P:      cfg_now.gain_p      = val[GAIN_W-1:0];
      REG_GAIN_D:      cfg_now.gain_d      = val[GAIN_W-1:0];
      REG_CENTER_DUTY: cfg_now.center_duty = val[DUTY_W-1:0];
      REG_STEER_MIN:   cfg_now.steer_min   = val[DUTY_W-1:0];
      REG_STEER_MAX:   cfg_now.steer_max   = val[DUTY_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_reg(input logic [2:0] idx);
    logic [31:0] want;
    case (idx)
      REG_GAIN_P:      want = 32'(cfg_now.gain_p);
      REG_GAIN_D:      want = 32'(cfg_now.gain_d);
      REG_CENTER_DUTY: want = 32'(cfg_now.center_duty);
      REG_STEER_MIN:   want = 32'(cfg_now.steer_min);
      default:         want = 32'(cfg_now.steer_max);
    endcase
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = {idx, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      note_fail($sformatf("reg %0d read exp %0d got %0d", idx, want, prdata));
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // all five registers, optionally with garbage above the field width
  task automatic apply_cfg(input int gp, input int gd, input int cd, input int mn,
                           input int mx, input bit junk);
    logic [31:0] upper;
    wait_drained();
    upper = junk ? ($urandom & 32'hFFFF_0000) : 32'h0;
    write_reg(REG_GAIN_P, upper | 32'(gp));
    write_reg(REG_GAIN_D, upper | 32'(gd));
    write_reg(REG_CENTER_DUTY, upper | 32'(cd));
    write_reg(REG_STEER_MIN, upper | 32'(mn));
    write_reg(REG_STEER_MAX, upper | 32'(mx));
    for (int i = REG_GAIN_P; i <= REG_STEER_MAX; i++) check_reg(3'(i));
  endtask

  function automatic int pick_value(input int top);
    int k;
    k = $urandom_range(9);
    if (k == 0) return 0;
    if (k == 1) return top;
    return $urandom_range(top);
  endfunction

  task automatic test_reset_registers();
    for (int i = REG_GAIN_P; i <= REG_STEER_MAX; i++) check_reg(3'(i));
  endtask

  task automatic test_directed_samples();
    send_samples(8'd5, 8'd5);
    send_samples(8'd255, 8'd255);
    send_samples(8'd0, 8'd0);
    send_samples(8'd255, 8'd0);
    send_samples(8'd0, 8'd255);
    send_samples(8'd1, 8'd0);
    send_samples(8'd0, 8'd1);
    send_samples(8'd128, 8'd128);
    send_samples(8'd170, 8'd85);
    send_samples(8'd85, 8'd170);
    send_samples(8'd254, 8'd255);
    send_samples(8'd200, 8'd3);
  endtask

  task automatic test_config_extremes();
    apply_cfg(GAIN_TOP, GAIN_TOP, DUTY_TOP, 0, DUTY_TOP, 1'b0);
    send_samples(8'd255, 8'd0);
    send_samples(8'd0, 8'd255);
    send_samples(8'd128, 8'd64);
    apply_cfg(0, 0, 0, 0, DUTY_TOP, 1'b0);
    send_samples(8'd77, 8'd33);
    apply_cfg(0, 0, DUTY_TOP, 0, DUTY_TOP, 1'b0);
    send_samples(8'd33, 8'd77);
    // crossed clamps
    apply_cfg(1200, 200, 838, DUTY_TOP, 0, 1'b1);
    send_samples(8'd255, 8'd0);
    send_samples(8'd10, 8'd240);
    apply_cfg(GAIN_TOP, 0, 5000, 4999, 5001, 1'b1);
    send_samples(8'd100, 8'd90);
    wait_drained();
    write_reg(REG_UNMAPPED, $urandom);
    write_reg(REG_TOP_HOLE, $urandom);
    for (int i = REG_GAIN_P; i <= REG_STEER_MAX; i++) check_reg(3'(i));
    send_samples(8'd90, 8'd100);
    send_samples(8'd0, 8'd0);
  endtask

  task automatic retune_random();
    int cd, mn, mx, k;
    cd = pick_value(DUTY_TOP);
    k  = $urandom_range(9);
    if (k == 0) begin
      mn = $urandom_range(DUTY_TOP);
      mx = $urandom_range(DUTY_TOP);
    end else if (k == 1) begin
      mn = 0;
      mx = DUTY_TOP;
    end else begin
      mn = $urandom_range(cd);
      mx = $urandom_range(DUTY_TOP, cd);
    end
    apply_cfg(pick_value(GAIN_TOP), pick_value(GAIN_TOP), cd, mn, mx,
              $urandom_range(3) == 0);
  endtask

  task automatic test_random_traffic();
    int         k;
    logic [7:0] ls, rs;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) apply_cfg(1200, 200, 838, 630, 1040, 1'b0);
      else retune_random();
      for (int n = 0; n < PHASE_WORDS; n++) begin
        k  = $urandom_range(99);
        ls = 8'($urandom);
        rs = 8'($urandom);
        if (k >= 50 && k < 70) begin
          rs = ls + 8'($urandom_range(8)) - 8'd4;
        end else if (k >= 70 && k < 80) begin
          if ($urandom_range(1)) rs = $urandom_range(1) ? 8'd0 : 8'd255;
          else ls = $urandom_range(1) ? 8'd0 : 8'd255;
        end else if (k >= 80 && k < 88) begin
          rs = $urandom_range(1) ? 8'd0 : ls;
          if (rs == 8'd0) ls = 8'd0;
        end else if (k >= 88) begin
          ls = 8'($urandom_range(3));
          rs = 8'($urandom_range(3));
        end
        send_samples(ls, rs);
      end
    end
  endtask

  task automatic test_unthrottled_burst();
    apply_cfg(1200, 200, 838, 630, 1040, 1'b0);
    idle_on = 1'b0;
    for (int n = 0; n < BURST_WORDS; n++) send_samples(8'($urandom), 8'($urandom));
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    cfg_now  = '{gain_p: GAIN_P_RST, gain_d: GAIN_D_RST, center_duty: CENTER_DUTY_RST,
                 steer_min: STEER_MIN_RST, steer_max: STEER_MAX_RST};
    l_hi     = PEAK_RST;
    l_lo     = FLOOR_RST;
    r_hi     = PEAK_RST;
    r_lo     = FLOOR_RST;
    last_err = 0;
    repeat (9) @(negedge clk);
    rst = 1'b0;
    test_reset_registers();
    test_directed_samples();
    test_config_extremes();
    test_random_traffic();
    test_unthrottled_burst();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_cnt == 0 && pending_steer_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
